@@ src/fpw_pkg.sv @@
// Shared types and constants for the two-plane framebuffer pixel writer.
// Geometry, action and color codes, and the controller/datapath command and status words.
// No dependencies.
`default_nettype none

package fpw_pkg;

	// Panel memory geometry
	localparam int MEM_WIDTH   = 128;
	localparam int MEM_HEIGHT  = 296;
	localparam int ROW_BYTES   = (MEM_WIDTH + 7) / 8;
	localparam int PLANE_BYTES = ROW_BYTES * MEM_HEIGHT;
	localparam int ADDR_W      = $clog2(PLANE_BYTES);

	// Action codes
	typedef enum logic [2:0] {
		ACT_CLEAR = 3'd0,
		ACT_PIXEL = 3'd1,
		ACT_HRUN  = 3'd2,
		ACT_VRUN  = 3'd3,
		ACT_READ  = 3'd4
	} action_t;

	// Color codes; anything else paints white
	localparam logic [1:0] COLOR_BLACK = 2'd1;
	localparam logic [1:0] COLOR_RED   = 2'd2;

	// Controller to datapath
	typedef struct packed {
		logic latch;       // capture the accepted word
		logic calc;        // map current pixel to address and bit
		logic step;        // advance run counter
		logic mem_rd;      // read plane word
		logic pix_wr;      // write back modified plane word
		logic clr_wr;      // write zero at the sweep address
		logic load_result; // load the result bytes
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic last_pix;    // current pixel is the last of the item
		logic clr_last;    // sweep is at the last address
	} status_t;

endpackage

`default_nettype wire

@@ src/two_plane_framebuffer_pixel_writer.sv @@
// Top level of the two-plane framebuffer pixel writer: controller plus datapath.
// Depends on fpw_pkg, fpw_ctrl and fpw_dp.
//
// Usage:
//   Command channel: present action, pos_x, pos_y, run_length, color and
//   byte_index with start high; the word is taken at a clock edge where
//   start is high and busy is low. busy stays high until the result is out.
//   Result channel: red_byte and black_byte are valid for exactly one cycle
//   while done is high; the receiver cannot stall, so it must take them then.
//   Every command gives one result (zero bytes unless a byte read below PLANE_BYTES).
//   Steps after accept: a pixel and each run pixel do calc, read, write
//   (one memory port); a zero-length run or unused code goes straight to
//   finish; a byte read does one read; clear zeroes one plane word per cycle.
//   Each command ends in the finish step; the next word is taken in idle.
//   Rotation: cfg_we writes cfg_data into the rotation register at any edge;
//   change it only while the block is idle.
//   Reset: arst_n low clears control state and rotation. After release the
//   block sweeps every address of both planes to zero with busy high;
//   rotation writes are taken during the sweep.
`default_nettype none

module two_plane_framebuffer_pixel_writer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         action,
	input  wire logic signed [10:0] pos_x,
	input  wire logic signed [10:0] pos_y,
	input  wire logic [9:0]         run_length,
	input  wire logic [1:0]         color,
	input  wire logic [12:0]        byte_index,
	output logic                    done,
	output logic [7:0]              red_byte,
	output logic [7:0]              black_byte,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_data
);
	import fpw_pkg::*;

	cmd_t    cmd;
	status_t status;

	fpw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.action     (action),
		.run_length (run_length),
		.status     (status),
		.cmd        (cmd),
		.busy       (busy),
		.done       (done)
	);

	fpw_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.action     (action),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.run_length (run_length),
		.color      (color),
		.byte_index (byte_index),
		.red_byte   (red_byte),
		.black_byte (black_byte)
	);

endmodule

`default_nettype wire

@@ src/fpw_dp.sv @@
// Datapath: captured word, rotation register, coordinate mapping and plane memory.
// Depends on fpw_pkg.
`default_nettype none

module fpw_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire fpw_pkg::cmd_t        cmd,
	output fpw_pkg::status_t          status,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_data,
	input  wire logic [2:0]           action,
	input  wire logic signed [10:0]   pos_x,
	input  wire logic signed [10:0]   pos_y,
	input  wire logic [9:0]           run_length,
	input  wire logic [1:0]           color,
	input  wire logic [12:0]          byte_index,
	output logic [7:0]                red_byte,
	output logic [7:0]                black_byte
);
	import fpw_pkg::*;

	localparam logic signed [11:0] LW_COL = 12'(MEM_WIDTH);
	localparam logic signed [11:0] LW_ROW = 12'(MEM_HEIGHT);
	localparam logic signed [11:0] COL_MAX = 12'(MEM_WIDTH - 1);
	localparam logic signed [11:0] ROW_MAX = 12'(MEM_HEIGHT - 1);

	logic [1:0]          rotation_q;
	action_t             action_q;
	logic signed [10:0]  x_q, y_q;
	logic [9:0]          len_q;
	logic [1:0]          color_q;
	logic [12:0]         bidx_q;
	logic [9:0]          cnt_q;
	logic [ADDR_W-1:0]   clr_addr_q;

	logic [ADDR_W-1:0]   addr_s1;
	logic [2:0]          bit_s1;
	logic                inb_s1;

	logic [15:0]         mem [PLANE_BYTES];
	logic [15:0]         rdata_q;

	logic signed [11:0]  px, py, lw, lh, col, row;
	logic [11:0]         col_u, row_u;
	logic                inb;
	logic [ADDR_W-1:0]   addr_c, rd_addr;
	logic [7:0]          mask, red_new, black_new;
	logic                byte_ok;

	// Rotation register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= 2'd0;
		end else if (cfg_we) begin
			rotation_q <= cfg_data;
		end
	end

	// Captured word
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			action_q <= action_t'(action);
			x_q      <= pos_x;
			y_q      <= pos_y;
			len_q    <= run_length;
			color_q  <= color;
			bidx_q   <= byte_index;
		end
	end

	// Run counter and clear sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			clr_addr_q <= '0;
		end else begin
			if (cmd.latch)
				cnt_q <= '0;
			else if (cmd.step)
				cnt_q <= cnt_q + 10'd1;
			if (cmd.clr_wr)
				clr_addr_q <= status.clr_last ? '0 : clr_addr_q + 1'b1;
		end
	end

	assign status.clr_last = (clr_addr_q == ADDR_W'(PLANE_BYTES - 1));
	assign status.last_pix = (action_q == ACT_PIXEL) || (cnt_q == len_q - 10'd1);

	// Logical position of current pixel, bounds check, rotation mapping
	always_comb begin
		px = 12'(x_q) + ((action_q == ACT_HRUN) ? signed'({2'b00, cnt_q}) : 12'sd0);
		py = 12'(y_q) + ((action_q == ACT_VRUN) ? signed'({2'b00, cnt_q}) : 12'sd0);
		lw = rotation_q[0] ? LW_COL : LW_ROW;
		lh = rotation_q[0] ? LW_ROW : LW_COL;
		inb = (px >= 12'sd0) && (px < lw) && (py >= 12'sd0) && (py < lh);
		case (rotation_q)
			2'd0: begin
				col = py;
				row = px;
			end
			2'd1: begin
				col = COL_MAX - px;
				row = py;
			end
			2'd2: begin
				col = COL_MAX - py;
				row = ROW_MAX - px;
			end
			default: begin
				col = px;
				row = ROW_MAX - py;
			end
		endcase
		col_u  = col;
		row_u  = row;
		addr_c = ADDR_W'(row_u) * ADDR_W'(ROW_BYTES) + ADDR_W'(col_u[11:3]);
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			addr_s1 <= addr_c;
			bit_s1  <= col_u[2:0];
			inb_s1  <= inb;
		end
	end

	// Read-modify-write data: clear both bits, then set the one for the color
	always_comb begin
		mask      = 8'h80 >> bit_s1;
		red_new   = (rdata_q[15:8] & (8'hFF ^ mask)) | ((color_q == COLOR_RED) ? mask : 8'h00);
		black_new = (rdata_q[7:0] & (8'hFF ^ mask)) | ((color_q == COLOR_BLACK) ? mask : 8'h00);
		rd_addr   = (action_q == ACT_READ) ? ADDR_W'(bidx_q) : addr_s1;
		byte_ok   = 32'(bidx_q) < PLANE_BYTES;
	end

	// Plane memory: red in the upper byte, black in the lower byte
	always_ff @(posedge clk) begin
		if (cmd.clr_wr)
			mem[clr_addr_q] <= '0;
		else if (cmd.pix_wr && inb_s1)
			mem[addr_s1] <= {red_new, black_new};
		if (cmd.mem_rd)
			rdata_q <= mem[rd_addr];
	end

	// Result bytes
	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			if (action_q == ACT_READ && byte_ok) begin
				red_byte   <= rdata_q[15:8];
				black_byte <= rdata_q[7:0];
			end else begin
				red_byte   <= 8'h00;
				black_byte <= 8'h00;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/fpw_ctrl.sv @@
// Controller: sequences clear sweeps, per-pixel read-modify-write and byte reads.
// Depends on fpw_pkg.
`default_nettype none

module fpw_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [2:0]        action,
	input  wire logic [9:0]        run_length,
	input  wire fpw_pkg::status_t  status,
	output fpw_pkg::cmd_t          cmd,
	output logic                   busy,
	output logic                   done
);
	import fpw_pkg::*;

	typedef enum logic [7:0] {
		S_INIT   = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_CLEAR  = 8'b0000_0100,
		S_CALC   = 8'b0000_1000,
		S_READ   = 8'b0001_0000,
		S_WRITE  = 8'b0010_0000,
		S_BYTE   = 8'b0100_0000,
		S_FINISH = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   done_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.clr_wr = 1'b1;
				if (status.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					unique case (action_t'(action)) inside
						ACT_CLEAR: state_d = S_CLEAR;
						ACT_PIXEL: state_d = S_CALC;
						ACT_HRUN, ACT_VRUN:
							state_d = (run_length == 10'd0) ? S_FINISH : S_CALC;
						ACT_READ:  state_d = S_BYTE;
						default:   state_d = S_FINISH;
					endcase
				end
			end
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (status.clr_last)
					state_d = S_FINISH;
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_READ;
			end
			S_READ: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_WRITE;
			end
			S_WRITE: begin
				cmd.pix_wr = 1'b1;
				if (status.last_pix) begin
					state_d = S_FINISH;
				end else begin
					cmd.step = 1'b1;
					state_d  = S_CALC;
				end
			end
			S_BYTE: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_FINISH;
			end
			S_FINISH: begin
				cmd.load_result = 1'b1;
				state_d         = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_FINISH);
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	// Result strobe only follows the finish step
	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_FINISH))
		else $error("result strobe without finish step");

	// Strobe lasts one cycle
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");

	// An accepted word always leaves idle
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start) |=> (state_q != S_IDLE))
		else $error("accepted word did not start work");

	// Unfinished runs go back to the next pixel
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE && !status.last_pix) |=> (state_q == S_CALC))
		else $error("run ended early");

endmodule

`default_nettype wire
